// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ===== rtl/tgbn_pkg.sv =====
// ----------------------------------------------------------------------------
// tgbn_pkg
// Shared types and constants of the toroidal grid blur block.
// ----------------------------------------------------------------------------
package tgbn_pkg;
    localparam int VAL_W   = 10;
    localparam int BW_W    = 9;
    localparam int NUM_W   = 22;
    localparam logic [BW_W-1:0] WEIGHT_ONE = 9'd256;
    localparam logic CFG_BLUR_WEIGHT = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BLUR_RD,
        ST_BLUR_ACC,
        ST_BLUR_WR,
        ST_DIV_RD,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_OUT
    } tgbn_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_wr;
        logic load_clr;
        logic cell_clr;
        logic pos_clr;
        logic nb_start;
        logic nb_step;
        logic blur_wr;
        logic cell_next;
        logic div_start;
        logic out_load;
    } tgbn_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic nb_done;
        logic cell_last;
        logic div_done;
    } tgbn_sts_t;
endpackage

// ===== rtl/tgbn_datapath.sv =====
// ----------------------------------------------------------------------------
// tgbn_datapath
// Grid memories, stencil accumulator, max tracker and serial divider.
// ----------------------------------------------------------------------------
module tgbn_datapath #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tgbn_pkg::tgbn_cmd_t      cmd,
    output tgbn_pkg::tgbn_sts_t      sts,
    input  logic [9:0]               cell_value,
    input  logic [8:0]               blur_weight,
    input  logic [9:0]               peak_target,
    output logic [9:0]               result_value
);
    import tgbn_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int IW = $clog2(CELLS);
    localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int LW = IW + 1;
    localparam int DIV_STEPS = 20;

    logic [VAL_W-1:0] src_mem [CELLS];
    logic [VAL_W-1:0] blr_mem [CELLS];

    logic [LW-1:0]    load_idx_reg;
    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic [IW-1:0]    cell_reg;
    logic [2:0]       nb_reg;
    logic [2:0]       nb_sel;
    logic [VAL_W-1:0] src_q_reg;
    logic [VAL_W-1:0] blr_q_reg;
    logic [VAL_W-1:0] centre_reg;
    logic [VAL_W+2:0] ring_reg;
    logic [VAL_W-1:0] largest_reg;
    logic [BW_W-1:0]  b_sat;
    logic [XW-1:0]    xl, xr, xs;
    logic [YW-1:0]    yu, yd, ys;
    logic [IW-1:0]    rd_addr;
    logic [NUM_W-1:0] num;
    logic [VAL_W-1:0] blur_val;
    logic             rd_phase_reg;

    // Divider: 20-bit dividend product over 10-bit divisor, one bit a cycle.
    logic [19:0]      dq_reg;
    logic [10:0]      rem_reg;
    logic [4:0]       dcnt_reg;
    logic             dbusy_reg;
    logic [10:0]      rem_sh;

    assign b_sat = (blur_weight > WEIGHT_ONE) ? WEIGHT_ONE : blur_weight;
    assign xl = (x_reg == '0) ? XW'(GRID_WIDTH - 1) : x_reg - 1'b1;
    assign xr = (x_reg == XW'(GRID_WIDTH - 1)) ? '0 : x_reg + 1'b1;
    assign yu = (y_reg == '0) ? YW'(GRID_HEIGHT - 1) : y_reg - 1'b1;
    assign yd = (y_reg == YW'(GRID_HEIGHT - 1)) ? '0 : y_reg + 1'b1;

    // Once the first read has been issued, the read address runs one
    // stencil point ahead of the accumulator.
    assign nb_sel = nb_reg + 3'(rd_phase_reg);

    always_comb
    begin
        xs = x_reg;
        ys = y_reg;
        unique case (nb_sel)
            3'd1:    xs = xl;
            3'd2:    xs = xr;
            3'd3:    ys = yu;
            3'd4:    ys = yd;
            default: xs = x_reg;
        endcase
    end

    assign rd_addr = IW'(ys * GRID_WIDTH + xs);
    assign sts.nb_done   = (nb_reg == 3'd5);
    assign sts.cell_last = (cell_reg == IW'(CELLS - 1));
    assign sts.div_done  = !dbusy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_idx_reg < LW'(CELLS))
        begin
            src_mem[load_idx_reg[IW-1:0]] <= cell_value;
        end
        src_q_reg <= src_mem[rd_addr];
        if (cmd.blur_wr)
        begin
            blr_mem[cell_reg] <= blur_val;
        end
        blr_q_reg <= blr_mem[cell_reg];
    end

    assign num = NUM_W'(centre_reg) * NUM_W'(b_sat) * NUM_W'(4)
               + NUM_W'(ring_reg) * NUM_W'(WEIGHT_ONE - b_sat);
    assign blur_val = num[19:10];
    assign rem_sh = {rem_reg[9:0], dq_reg[19]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            cell_reg     <= '0;
            nb_reg       <= '0;
            largest_reg  <= '0;
            dbusy_reg    <= 1'b0;
            dcnt_reg     <= '0;
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_clr)
            begin
                load_idx_reg <= '0;
            end
            else if (cmd.load_wr && load_idx_reg < LW'(CELLS))
            begin
                load_idx_reg <= load_idx_reg + 1'b1;
            end
            if (cmd.cell_clr)
            begin
                x_reg       <= '0;
                y_reg       <= '0;
                cell_reg    <= '0;
                largest_reg <= '0;
            end
            else if (cmd.pos_clr)
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                cell_reg <= '0;
            end
            else if (cmd.cell_next)
            begin
                cell_reg <= cell_reg + 1'b1;
                if (x_reg == XW'(GRID_WIDTH - 1))
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            if (cmd.blur_wr && blur_val > largest_reg)
            begin
                largest_reg <= blur_val;
            end
            if (cmd.nb_start)
            begin
                nb_reg       <= '0;
                rd_phase_reg <= 1'b0;
            end
            else if (cmd.nb_step)
            begin
                rd_phase_reg <= 1'b1;
                if (rd_phase_reg)
                begin
                    nb_reg <= nb_reg + 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == 5'(DIV_STEPS - 1))
                begin
                    dbusy_reg <= 1'b0;
                end
            end
        end
    end

    // The memory read is registered; since the address runs
    // one point ahead, the accumulator sees the value for its own index.
    always_ff @(posedge clk)
    begin
        if (cmd.nb_step && rd_phase_reg)
        begin
            if (nb_reg == 3'd0)
            begin
                centre_reg <= src_q_reg;
                ring_reg   <= '0;
            end
            else
            begin
                ring_reg <= ring_reg + (VAL_W+3)'(src_q_reg);
            end
        end
        if (cmd.div_start)
        begin
            dq_reg  <= 20'(blr_q_reg) * 20'(peak_target);
            rem_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            if (rem_sh >= {1'b0, largest_reg})
            begin
                rem_reg <= rem_sh - {1'b0, largest_reg};
                dq_reg  <= {dq_reg[18:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dq_reg  <= {dq_reg[18:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            result_value <= (largest_reg == '0) ? '0 : dq_reg[9:0];
        end
    end
endmodule

// ===== rtl/tgbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgbn_ctrl
// Sequencer for load, blur pass, and normalize/output pass.
// ----------------------------------------------------------------------------
module tgbn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tlast,
    output tgbn_pkg::tgbn_cmd_t  cmd,
    input  tgbn_pkg::tgbn_sts_t  sts
);
    import tgbn_pkg::*;

    tgbn_state_t state_reg, state_next;
    logic        mv_reg, mv_next;
    logic        ml_reg, ml_next;
    logic        s_acc, m_acc;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = mv_reg && m_tready;
    assign s_tready = (state_reg == ST_LOAD) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tlast  = ml_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_acc && s_last) state_next = ST_BLUR_RD;
            ST_BLUR_RD:   state_next = ST_BLUR_ACC;
            ST_BLUR_ACC:  if (sts.nb_done) state_next = ST_BLUR_WR;
            ST_BLUR_WR:   state_next = sts.cell_last ? ST_DIV_RD : ST_BLUR_RD;
            ST_DIV_RD:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:   if (sts.div_done && (!mv_reg || m_tready)) state_next = ST_OUT;
            ST_OUT:       state_next = ml_next ? ST_LOAD : ST_DIV_RD;
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        mv_next = mv_reg && !m_acc;
        ml_next = ml_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load_wr  = s_acc;
                cmd.cell_clr = 1'b1;
                cmd.nb_start = 1'b1;
            end
            ST_BLUR_RD:   cmd.nb_step = 1'b1;
            ST_BLUR_ACC:  cmd.nb_step = !sts.nb_done;
            ST_BLUR_WR:
            begin
                cmd.blur_wr   = 1'b1;
                cmd.nb_start  = 1'b1;
                cmd.cell_next = !sts.cell_last;
                cmd.pos_clr   = sts.cell_last;
                cmd.cell_clr  = 1'b0;
            end
            ST_DIV_RD:    cmd.load_clr = 1'b1;
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                cmd.load_clr  = 1'b1;
            end
            ST_DIV_RUN:
            begin
                if (sts.div_done && (!mv_reg || m_tready))
                begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    ml_next      = sts.cell_last;
                end
            end
            ST_OUT:       cmd.cell_next = !ml_reg;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            mv_reg    <= 1'b0;
            ml_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            ml_reg    <= (state_reg == ST_LOAD && s_acc) ? 1'b0 : ml_next;
        end
    end
endmodule

// ===== rtl/toroidal_grid_blur_normalize.sv =====
// ----------------------------------------------------------------------------
// toroidal_grid_blur_normalize
// Five-point wrap-around blur of a loaded grid, scaled to a target maximum.
// ----------------------------------------------------------------------------
// Cells are loaded one beat per cycle in row order. The beat with tlast set
// starts the work: each cell is blurred from the original values by one
// source memory read per stencil point plus a read, a settle and a write
// step, then each result is scaled by the target peak register over the
// largest blurred value with a bit-serial divider, one cell at a time; the
// next division runs while a result beat waits to be taken. No new
// cells are taken until the last result beat has been accepted downstream.
// Configuration writes are always accepted and should only be issued while
// no grid is being processed.
module toroidal_grid_blur_normalize #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] cell_value
    input  logic        s_tlast,   // last_cell
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] result_value
    output logic        m_tlast,   // result_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import tgbn_pkg::*;

    tgbn_cmd_t   cmd;
    tgbn_sts_t   sts;
    logic [8:0]  bw_reg;
    logic [9:0]  mcp_reg;
    logic [9:0]  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg  <= 9'd128;
            mcp_reg <= 10'd1000;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BLUR_WEIGHT)
            begin
                bw_reg <= cfg_data[8:0];
            end
            else
            begin
                mcp_reg <= cfg_data[9:0];
            end
        end
    end

    tgbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_last   (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    tgbn_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cell_value   (s_tdata[9:0]),
        .blur_weight  (bw_reg),
        .peak_target  (mcp_reg),
        .result_value (res)
    );

    assign m_tdata = {6'd0, res};
endmodule

// ===== rtl/tgbn_checker.sv =====
// ----------------------------------------------------------------------------
// tgbn_port_checks
// Port-level checks of the grid blur block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tgbn_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `CHK_IMPLY(a_nocross, clk, rst_n, m_tvalid, !s_tready)
    `CHK_NEXT(a_lastin, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)
    `CHK_IMPLY(a_pad, clk, rst_n, m_tvalid, m_tdata[15:10] == 6'd0)
endmodule

bind toroidal_grid_blur_normalize tgbn_port_checks u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== sim/tgbn_checker.sv =====
// ----------------------------------------------------------------------------
// tgbn_checker
// Predicts and checks the result beats of the grid blur block.
// ----------------------------------------------------------------------------
// Watches the cell, result and configuration channels. It keeps its own
// copy of the grid and the registers and computes all results of a grid
// when the beat with tlast is accepted.
module tgbn_checker #(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked
);
    import tgbn_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last;
    } cell_result_t;

    logic [VAL_W-1:0] grid_cells [CELLS];
    logic [BW_W-1:0]  weight;
    logic [VAL_W-1:0] target_max;
    int               fill_pos;
    cell_result_t     expected_cells [$];

    function automatic int unsigned blurred_at(int y, int x, int unsigned b);
        int xl;
        int xr;
        int yu;
        int yd;
        int unsigned ring;
        int unsigned num;
        xl = (x == 0) ? GRID_WIDTH - 1 : x - 1;
        xr = (x == GRID_WIDTH - 1) ? 0 : x + 1;
        yu = (y == 0) ? GRID_HEIGHT - 1 : y - 1;
        yd = (y == GRID_HEIGHT - 1) ? 0 : y + 1;
        ring = grid_cells[y*GRID_WIDTH + xl] + grid_cells[y*GRID_WIDTH + xr]
             + grid_cells[yu*GRID_WIDTH + x] + grid_cells[yd*GRID_WIDTH + x];
        num = grid_cells[y*GRID_WIDTH + x] * b * 4 + ring * (256 - b);
        return (num / 1024) & 10'h3ff;
    endfunction

    // Blurs the whole grid from the stored values, then scales every cell.
    task automatic predict_grid();
        int unsigned b;
        int unsigned blurred [CELLS];
        int unsigned peak;
        cell_result_t r;
        b = (weight > WEIGHT_ONE) ? 256 : weight;
        peak = 0;
        for (int y = 0; y < GRID_HEIGHT; y++)
        begin
            for (int x = 0; x < GRID_WIDTH; x++)
            begin
                blurred[y*GRID_WIDTH + x] = blurred_at(y, x, b);
                if (blurred[y*GRID_WIDTH + x] > peak)
                    peak = blurred[y*GRID_WIDTH + x];
            end
        end
        for (int i = 0; i < CELLS; i++)
        begin
            r.value = (peak == 0) ? '0 : VAL_W'((blurred[i] * target_max) / peak);
            r.last  = (i == CELLS - 1);
            expected_cells.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight     <= 9'd128;
            target_max <= 10'd1000;
            fill_pos   = 0;
            errors     = 0;
            checked    = 0;
            expected_cells.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BLUR_WEIGHT)
                    weight <= cfg_data[BW_W-1:0];
                else
                    target_max <= cfg_data[VAL_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                // Cells beyond a full grid are dropped until tlast arrives.
                if (fill_pos < CELLS)
                begin
                    grid_cells[fill_pos] = s_tdata[VAL_W-1:0];
                    fill_pos++;
                end
                if (s_tlast)
                begin
                    predict_grid();
                    fill_pos = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (expected_cells.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: value %0d last %0b",
                                 m_tdata[VAL_W-1:0], m_tlast);
                end
                else
                begin
                    cell_result_t e;
                    e = expected_cells.pop_front();
                    if (e.value !== m_tdata[VAL_W-1:0] || e.last !== m_tlast)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected value %0d last %0b, got %0d last %0b",
                                     e.value, e.last, m_tdata[VAL_W-1:0], m_tlast);
                    end
                end
            end
        end
        pending = expected_cells.size();
    end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the toroidal grid blur block.
// ----------------------------------------------------------------------------
// Sends grids of cells (full, short, overfull, all zero, all maximum) under
// several handshake idling patterns and register settings, while a checker
// beside the block predicts and compares every result beat.
module testbench;
    import tgbn_pkg::*;

    localparam logic CFG_MAX_PRODUCTION = ~CFG_BLUR_WEIGHT;
    localparam int   CELLS      = 64;
    localparam int   IDLE_LIMIT = 20000;

    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_EXTREME } fill_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          checked;
    int          send_idle_pct;
    int          sink_stall_pct;
    int          cells_sent;
    int          grids_sent;
    int          quiet_cycles;

    toroidal_grid_blur_normalize i_dut (.*);

    tgbn_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls at random, sampled by the block at the next edge.
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_stall_pct);

    // Watchdog: ends the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic index, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_cell(input logic [9:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, value};
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        cells_sent++;
    endtask

    task automatic send_grid(input int count, input fill_kind_t kind);
        logic [9:0] v;
        for (int i = 0; i < count; i++)
        begin
            case (kind)
                FILL_ZERO:    v = '0;
                FILL_FULL:    v = 10'h3ff;
                FILL_EXTREME: v = (i % 3 == 0) ? 10'h3ff : ((i % 3 == 1) ? 10'd0 : 10'd1);
                default:      v = 10'($urandom_range(1023));
            endcase
            send_cell(v, i == count - 1);
        end
        s_tvalid = 1'b0;
        grids_sent++;
    endtask

    // Holds the cell side until every predicted result has left the block.
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_grid();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            send_grid(CELLS, FILL_RANDOM);
        else if (pick < 80)
            send_grid($urandom_range(1, CELLS - 1), FILL_RANDOM);
        else if (pick < 90)
            send_grid($urandom_range(CELLS + 1, CELLS + 6), FILL_RANDOM);
        else if (pick < 95)
            send_grid(CELLS, FILL_EXTREME);
        else
            send_grid(CELLS, FILL_ZERO);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_BLUR_WEIGHT;
        cfg_data       = '0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        cells_sent     = 0;
        grids_sent     = 0;
        quiet_cycles   = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first grid is always complete, so that later
        // short grids never read a cell that was not written since reset.
        write_reg(CFG_BLUR_WEIGHT, 16'd256);
        write_reg(CFG_MAX_PRODUCTION, 16'd1023);
        send_grid(CELLS, FILL_FULL);
        send_grid(1, FILL_ZERO);
        send_grid(CELLS + 6, FILL_EXTREME);
        drain();
        // Pure neighbour blur with the smallest nonzero target, on an all-zero grid and a short full grid.
        write_reg(CFG_BLUR_WEIGHT, 16'd0);
        write_reg(CFG_MAX_PRODUCTION, 16'd1);
        send_grid(CELLS, FILL_ZERO);
        send_grid(2, FILL_FULL);
        drain();
        // Weight above one saturates, and a zero target clears every result.
        write_reg(CFG_BLUR_WEIGHT, 16'h1ff);
        write_reg(CFG_MAX_PRODUCTION, 16'd0);
        send_grid(CELLS / 2, FILL_RANDOM);
        drain();

        // Random part cycling through four idling patterns, at least four phases, new register values per phase.
        for (int phase = 0; phase < 4 || cells_sent < 420; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin send_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            write_reg(CFG_BLUR_WEIGHT, 16'($urandom_range(511)));
            write_reg(CFG_MAX_PRODUCTION, ($urandom_range(3) == 0) ? 16'd1023
                                                                    : 16'($urandom_range(1023)));
            random_grid();
            drain();
        end

        drain();
        repeat (200) @(negedge clk);
        $display("Covered %0d grids from %0d cell beats; %0d result beats compared.",
                 grids_sent, cells_sent, checked);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
